>>> rtl/lle_pkg.sv
// ============================================================================
// lle_pkg
// Shared constants for the linked list engine: default sizes, field widths,
// command codes and status codes.
// ============================================================================
package lle_pkg;

    // Default pool size and stored value width
    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the transaction ports
    localparam int MODE_W     = 2;
    localparam int IN_VALUE_W = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 7;

    // Command codes
    localparam logic [MODE_W-1:0] MODE_INS_HEAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INS_TAIL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

>>> rtl/lle_ram.sv
// ============================================================================
// lle_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ============================================================================
module lle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/linked_list_engine.sv
// ============================================================================
// linked_list_engine
// Singly linked list of values in a fixed node pool. Commands insert at the
// head, insert at the tail, or remove the first node holding a value.
// ============================================================================
// Sequence: insert writes the new node, and at the tail of a non-empty list
//   then links it behind the old tail; pool full or empty-list remove go
//   straight to the result; remove walks up to the matching node or the end.
// Throughput: one transaction at a time; the remove walk reads one node per
//   cycle from the value and link memories, so it is the longest transaction.
// Reset: synchronous, active low; the list comes up empty with the whole
//   pool available and needs no clearing pass.
// ============================================================================
module linked_list_engine
    import lle_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic        [MODE_W-1:0]     i_mode,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic        [STATUS_W-1:0]   o_status,
    output logic        [COUNT_W-1:0]    o_count
);

    // Index width addresses the pool; pointer width also holds the null marker
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a command
        S_INS,    // write the new node, pop the free list when reusing a node
        S_LINK,   // hook the new node behind the old tail
        S_WALK,   // compare one node per cycle
        S_FREE,   // push the removed node onto the free list
        S_EMIT    // hand the result to the output register
    } t_state;

    t_state                  r_state;
    logic [MODE_W-1:0]       r_mode;
    logic [VALUE_WIDTH-1:0]  r_key;
    logic [IW-1:0]           r_node;
    logic                    r_from_free;
    logic [IW-1:0]           r_cur;
    logic [PW-1:0]           r_prev;
    logic [PW-1:0]           r_head;
    logic [PW-1:0]           r_tail;
    logic [PW-1:0]           r_free_head;
    logic [PW-1:0]           r_fresh;
    logic [CW-1:0]           r_count;
    logic [STATUS_W-1:0]     r_res_status;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [COUNT_W-1:0]      r_out_count;

    logic [VALUE_WIDTH-1:0]  w_key;
    logic [COUNT_W-1:0]      w_count_out;
    logic                    w_accept;
    logic                    w_match;

    // memory ports
    logic                    w_val_we;
    logic [IW-1:0]           w_val_waddr;
    logic [IW-1:0]           w_val_raddr;
    logic [VALUE_WIDTH-1:0]  w_val_rdata;
    logic                    w_lnk_we;
    logic [IW-1:0]           w_lnk_waddr;
    logic [PW-1:0]           w_lnk_wdata;
    logic [IW-1:0]           w_lnk_raddr;
    logic [PW-1:0]           w_lnk_rdata;

    // Stored key: low bits of the command value, zero above the 32 input bits
    generate
        if (VALUE_WIDTH <= IN_VALUE_W) begin : g_key_trunc
            assign w_key = i_value[VALUE_WIDTH-1:0];
        end else begin : g_key_ext
            assign w_key = {{(VALUE_WIDTH - IN_VALUE_W){1'b0}}, i_value};
        end
        // Result count field keeps the low bits of the node count
        if (CW >= COUNT_W) begin : g_cnt_trunc
            assign w_count_out = r_count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_out = {{(COUNT_W - CW){1'b0}}, r_count};
        end
    endgenerate

    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    assign w_match  = (w_val_rdata == r_key);

    // ------------------------------------------------------------------
    // Memory addressing. Reads are issued in the cycle before the data is used:
    //   idle  - free-list head (insert) or list head (remove)
    //   walk  - the successor just read, so the next node lands next cycle
    // ------------------------------------------------------------------
    always_comb begin
        w_val_raddr = r_cur;
        w_lnk_raddr = r_cur;
        case (r_state)
            S_IDLE: begin
                w_val_raddr = r_head[IW-1:0];
                w_lnk_raddr = (i_mode == MODE_REMOVE) ? r_head[IW-1:0]
                                                      : r_free_head[IW-1:0];
            end
            S_WALK: begin
                w_val_raddr = w_lnk_rdata[IW-1:0];
                w_lnk_raddr = w_lnk_rdata[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    // Writes: value only when a node is filled; links at most once a cycle
    always_comb begin
        w_val_we    = (r_state == S_INS);
        w_val_waddr = r_node;
        w_lnk_we    = 1'b0;
        w_lnk_waddr = r_node;
        w_lnk_wdata = NIL;
        case (r_state)
            S_INS: begin
                // new node ends the list unless it goes in front of a head
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_node;
                w_lnk_wdata = (r_head == NIL || r_mode == MODE_INS_TAIL) ? NIL : r_head;
            end
            S_LINK: begin
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_prev[IW-1:0];
                w_lnk_wdata = PW'(r_node);
            end
            S_WALK: begin
                // unlink a matching middle or tail node from its predecessor
                w_lnk_we    = w_match && (r_prev != NIL);
                w_lnk_waddr = r_prev[IW-1:0];
                w_lnk_wdata = w_lnk_rdata;
            end
            S_FREE: begin
                w_lnk_we    = 1'b1;
                w_lnk_waddr = r_cur;
                w_lnk_wdata = r_free_head;
            end
            default: begin
            end
        endcase
    end

    lle_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_waddr),
        .i_wdata (r_key),
        .i_raddr (w_val_raddr),
        .o_rdata (w_val_rdata)
    );

    lle_ram #(
        .WIDTH (PW),
        .DEPTH (CAPACITY)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_waddr (w_lnk_waddr),
        .i_wdata (w_lnk_wdata),
        .i_raddr (w_lnk_raddr),
        .o_rdata (w_lnk_rdata)
    );

    // ------------------------------------------------------------------
    // Control sequencer, list registers and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_free_head <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drain the output register once the consumer takes it, unless
            // the next result lands in the same cycle
            if (r_out_valid && !i_out_stall && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode <= i_mode;
                        r_key  <= w_key;
                        case (i_mode) inside
                            MODE_INS_HEAD, MODE_INS_TAIL: begin
                                if (r_free_head != NIL) begin
                                    // reuse a released node
                                    r_node      <= r_free_head[IW-1:0];
                                    r_from_free <= 1'b1;
                                    r_state     <= S_INS;
                                end else if (r_fresh != NIL) begin
                                    // hand out a never-used node
                                    r_node      <= r_fresh[IW-1:0];
                                    r_from_free <= 1'b0;
                                    r_fresh     <= r_fresh + PW'(1);
                                    r_state     <= S_INS;
                                end else begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_EMIT;
                                end
                            end
                            MODE_REMOVE: begin
                                if (r_head == NIL) begin
                                    r_res_status <= ST_NOT_FOUND;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_cur   <= r_head[IW-1:0];
                                    r_prev  <= NIL;
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                // unused command: no change
                                r_res_status <= ST_NOT_FOUND;
                                r_state      <= S_EMIT;
                            end
                        endcase
                    end
                end

                S_INS: begin
                    // link read issued at accept returns the free-list successor
                    if (r_from_free) begin
                        r_free_head <= w_lnk_rdata;
                    end
                    r_count      <= r_count + CW'(1);
                    r_res_status <= ST_INSERTED;
                    r_state      <= S_EMIT;
                    if (r_head == NIL) begin
                        r_head <= PW'(r_node);
                        r_tail <= PW'(r_node);
                    end else if (r_mode == MODE_INS_TAIL) begin
                        r_prev  <= r_tail;
                        r_tail  <= PW'(r_node);
                        r_state <= S_LINK;
                    end else begin
                        r_head <= PW'(r_node);
                    end
                end

                S_LINK: begin
                    r_state <= S_EMIT;
                end

                S_WALK: begin
                    if (w_match) begin
                        if (r_prev == NIL) begin
                            r_head <= w_lnk_rdata;
                        end
                        if (w_lnk_rdata == NIL) begin
                            r_tail <= r_prev;
                        end
                        if (r_count != '0) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_res_status <= ST_REMOVED;
                        r_state      <= S_FREE;
                    end else if (w_lnk_rdata == NIL) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_EMIT;
                    end else begin
                        // advance to the successor
                        r_prev <= PW'(r_cur);
                        r_cur  <= w_lnk_rdata[IW-1:0];
                    end
                end

                S_FREE: begin
                    r_free_head <= PW'(r_cur);
                    r_state     <= S_EMIT;
                end

                S_EMIT: begin
                    // hold until the output register is free or draining
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_count  <= w_count_out;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;

endmodule
